>>> hw/rtl/sobel_edge_dilate_erode_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the edge/morphology pipeline
// Shared helpers for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_DILATE_ERODE_TOP_DEFINES_SVH
`define SOBEL_EDGE_DILATE_ERODE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SEDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sede_pkg.sv
// ---------------------------------------------------------------------------
// sede_pkg
// Types and constants shared by the edge/morphology pipeline.
// ---------------------------------------------------------------------------
package sede_pkg;

  localparam int COL_W      = 12;
  localparam int ROW_W      = 13;
  localparam int DIM_W      = 13;
  localparam int PIX_W      = 8;
  localparam int LIM_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [10:0]      RST_WIDTH  = 11'd640;
  localparam logic [11:0]      RST_HEIGHT = 12'd480;
  localparam logic [LIM_W-1:0] RST_LIM_SQ = 17'd10201;  // (100+1)^2

  // neighbor mask bit positions
  localparam int MSK_TOP    = 3;
  localparam int MSK_BOTTOM = 2;
  localparam int MSK_LEFT   = 1;
  localparam int MSK_RIGHT  = 0;

  typedef struct packed {
    logic [COL_W-1:0] col;       // line buffer address
    logic [PIX_W-1:0] pixel;
    logic             border1;   // sobel center on image border
    logic [3:0]       m2;        // in-image neighbors, dilate center
    logic [3:0]       m3;        // in-image neighbors, erode center
    logic             p3_valid;  // this item emits a result
    logic             p3_last;   // result is last of the frame
  } item_t;

endpackage

>>> hw/rtl/sede_ram.sv
// ---------------------------------------------------------------------------
// sede_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module sede_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/sede_pos.sv
// ---------------------------------------------------------------------------
// sede_pos
// Config registers and raster counters; tags each item with the
// positions of the three window centers that trail it.
// ---------------------------------------------------------------------------
module sede_pos import sede_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  command,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  item_valid,
  output item_t                 item,
  output logic [LIM_W-1:0]      lim_sq
);

  logic [10:0]      width_reg;
  logic [11:0]      height_reg;
  logic [DIM_W-1:0] eff_w;
  logic [11:0]      eff_h;
  logic [COL_W-1:0] ct;
  logic [ROW_W-1:0] rt;
  logic [8:0]       thr_p1;
  logic [17:0]      prod;
  logic             drop;
  logic             wrap;

  logic [COL_W-1:0]        ck [1:3];
  logic signed [ROW_W:0]   rk [1:3];
  logic [3:0]              mk [1:3];
  logic                    vk [1:3];
  logic signed [ROW_W:0]   h_s;

  assign thr_p1 = {1'b0, cfg_data[7:0]} + 9'd1;
  assign prod   = thr_p1 * thr_p1;

  always_comb begin
    if ({2'b00, width_reg} < DIM_W'(3)) begin
      eff_w = DIM_W'(3);
    end else if ({2'b00, width_reg} > DIM_W'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = {2'b00, width_reg};
    end
    eff_h = (height_reg < 12'd3) ? 12'd3 : height_reg;
  end

  assign h_s = $signed({2'b00, eff_h});

  always_comb begin
    for (int k = 1; k <= 3; k++) begin
      if (ct < COL_W'(k)) begin
        ck[k] = ct + eff_w[COL_W-1:0] - COL_W'(k);
        rk[k] = $signed({1'b0, rt}) - (ROW_W+1)'(k + 1);
      end else begin
        ck[k] = ct - COL_W'(k);
        rk[k] = $signed({1'b0, rt}) - (ROW_W+1)'(k);
      end
      vk[k] = (rk[k] >= 0) && (rk[k] < h_s);
      mk[k][MSK_TOP]    = rk[k] > 0;
      mk[k][MSK_BOTTOM] = rk[k] < h_s - 1;
      mk[k][MSK_LEFT]   = ck[k] != '0;
      mk[k][MSK_RIGHT]  = {1'b0, ck[k]} != eff_w - DIM_W'(1);
    end
  end

  // frame still arriving and no pixel: item has no effect
  assign drop = ({1'b0, rt} < {2'b00, eff_h}) && (command == CMD_DRAIN);
  assign wrap = ({1'b0, ct} + DIM_W'(1)) >= eff_w;

  assign item_valid    = accept && !drop;
  assign item.col      = ct;
  assign item.pixel    = pixel;
  assign item.border1  = !(mk[1][MSK_TOP] && mk[1][MSK_BOTTOM]
                           && mk[1][MSK_LEFT] && mk[1][MSK_RIGHT]);
  assign item.m2       = mk[2];
  assign item.m3       = mk[3];
  assign item.p3_valid = vk[3];
  assign item.p3_last  = vk[3] && !mk[3][MSK_BOTTOM] && !mk[3][MSK_RIGHT];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= RST_WIDTH;
      height_reg <= RST_HEIGHT;
      lim_sq     <= RST_LIM_SQ;
      ct         <= '0;
      rt         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: lim_sq <= prod[LIM_W-1:0];
        REG_WIDTH: begin
          width_reg <= cfg_data[10:0];
          ct        <= '0;
          rt        <= '0;
        end
        REG_HEIGHT: begin
          height_reg <= cfg_data[11:0];
          ct         <= '0;
          rt         <= '0;
        end
        default: ;
      endcase
    end else if (item_valid) begin
      if (item.p3_last || wrap) begin
        ct <= '0;
      end else begin
        ct <= ct + COL_W'(1);
      end
      if (item.p3_last) begin
        rt <= '0;
      end else if (wrap) begin
        rt <= rt + ROW_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/sede_sobel.sv
// ---------------------------------------------------------------------------
// sede_sobel
// Grey line buffer, 3x3 window and gradient threshold. Four stages.
// ---------------------------------------------------------------------------
module sede_sobel import sede_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  item_t            in_item,
  input  logic [LIM_W-1:0] lim_sq,
  output logic             out_valid,
  output item_t            out_item,
  output logic             out_edge
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic             v0, v1, v2, v3;
  item_t            it0, it1, it2, it3;
  logic [2*PIX_W-1:0] rdata;
  logic [PIX_W-1:0] gwin [3][3];
  logic [9:0]       px, nx, py, ny;
  logic signed [10:0] gx, gy;
  logic [9:0]       mx, my;
  logic [6:0]       agx, agy;
  logic [13:0]      sqx, sqy;
  logic [14:0]      sum;

  // word: [15:8] one row up, [7:0] two rows up
  sede_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
    .clk   (clk),
    .we    (en && v0),
    .waddr (it0.col[AW-1:0]),
    .wdata ({it0.pixel, rdata[2*PIX_W-1:PIX_W]}),
    .re    (en && in_valid),
    .raddr (in_item.col[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= in_item;
      it1 <= it0;
      it2 <= it1;
      it3 <= it2;
      agx <= mx[9:3];
      agy <= my[9:3];
      sqx <= agx * agx;
      sqy <= agy * agy;
      if (v0) begin
        for (int r = 0; r < 3; r++) begin
          gwin[r][0] <= gwin[r][1];
          gwin[r][1] <= gwin[r][2];
        end
        gwin[0][2] <= rdata[PIX_W-1:0];
        gwin[1][2] <= rdata[2*PIX_W-1:PIX_W];
        gwin[2][2] <= it0.pixel;
      end
    end
  end

  always_comb begin
    py = {2'b00, gwin[2][0]} + {1'b0, gwin[2][1], 1'b0} + {2'b00, gwin[2][2]};
    ny = {2'b00, gwin[0][0]} + {1'b0, gwin[0][1], 1'b0} + {2'b00, gwin[0][2]};
    px = {2'b00, gwin[0][2]} + {1'b0, gwin[1][2], 1'b0} + {2'b00, gwin[2][2]};
    nx = {2'b00, gwin[0][0]} + {1'b0, gwin[1][0], 1'b0} + {2'b00, gwin[2][0]};
    gy = $signed({1'b0, py}) - $signed({1'b0, ny});
    gx = $signed({1'b0, px}) - $signed({1'b0, nx});
    // |x|/8 equals |x/8| with truncation toward zero
    my = gy[10] ? 10'(-gy) : gy[9:0];
    mx = gx[10] ? 10'(-gx) : gx[9:0];
  end

  assign sum       = {1'b0, sqx} + {1'b0, sqy};
  assign out_valid = v3;
  assign out_item  = it3;
  assign out_edge  = it3.border1 || ({2'b00, sum} < lim_sq);

endmodule

>>> hw/rtl/sede_morph.sv
// ---------------------------------------------------------------------------
// sede_morph
// Binary line buffer and 3x3 window: dilate white, or erode with black
// neighbors. Two stages.
// ---------------------------------------------------------------------------
module sede_morph import sede_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter bit ERODE     = 1'b0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  item_t in_item,
  input  logic  in_bit,
  output logic  out_valid,
  output item_t out_item,
  output logic  out_bit
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic       v0, v1;
  item_t      it0, it1;
  logic       b0;
  logic [1:0] rdata;
  logic       win [3][3];
  logic [3:0] msk;
  logic       rok [3];
  logic       cok [3];
  logic       any_w, all_w;

  // word: [1] one row up, [0] two rows up
  sede_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_ram (
    .clk   (clk),
    .we    (en && v0),
    .waddr (it0.col[AW-1:0]),
    .wdata ({b0, rdata[1]}),
    .re    (en && in_valid),
    .raddr (in_item.col[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= in_item;
      b0  <= in_bit;
      it1 <= it0;
      if (v0) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= rdata[0];
        win[1][2] <= rdata[1];
        win[2][2] <= b0;
      end
    end
  end

  assign msk = ERODE ? it1.m3 : it1.m2;

  always_comb begin
    rok[0] = msk[MSK_TOP];
    rok[1] = 1'b1;
    rok[2] = msk[MSK_BOTTOM];
    cok[0] = msk[MSK_LEFT];
    cok[1] = 1'b1;
    cok[2] = msk[MSK_RIGHT];
    any_w  = 1'b0;
    all_w  = 1'b1;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rok[r] && cok[c]) begin
          any_w = any_w | win[r][c];
          if (!(r == 1 && c == 1)) begin
            all_w = all_w & win[r][c];
          end
        end
      end
    end
  end

  assign out_valid = v1;
  assign out_item  = it1;
  assign out_bit   = ERODE ? all_w : any_w;

endmodule

>>> hw/rtl/sobel_edge_dilate_erode_top.sv
// ---------------------------------------------------------------------------
// sobel_edge_dilate_erode_top
// Sobel edge mark, 3x3 dilation of white, 3x3 erosion of white, streaming.
// ---------------------------------------------------------------------------
//   channel  | dir | payload
//   s_*      | in  | tdata[7:0] pixel_value, tuser command
//   m_*      | out | tdata[0] out_valid, tdata[1] out_white, tlast frame_last
//   cfg_*    | in  | index 0 threshold, 1 width, 2 height
//
// One item per clock while the output buffer has room; each stage line
// buffer is one RAM doing a read and a write per item. The result for
// raster position p rides on the item of p + 3*(width+1).
// Synchronous reset clears control state only; line buffers need no clear.
// s_tready drops only while the two-entry output buffer is full.
// ---------------------------------------------------------------------------
`include "sobel_edge_dilate_erode_top_defines.svh"

module sobel_edge_dilate_erode_top import sede_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] pixel_value
  input  logic                  s_tuser,   // [0] command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [0] out_valid, [1] out_white
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic             en;
  logic             pos_v, sob_v, dil_v, ero_v;
  item_t            pos_it, sob_it, dil_it, ero_it;
  logic             edge_w, grown_w, white;
  logic [LIM_W-1:0] lim_sq;
  logic [1:0]       fifo_cnt;
  logic [1:0]       fd0, fd1;  // {last, white}
  logic             push, pop;
  logic [1:0]       slot;

  assign en       = fifo_cnt != 2'd2;
  assign s_tready = en;

  sede_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (s_tvalid && s_tready),
    .command    (s_tuser),
    .pixel      (s_tdata),
    .item_valid (pos_v),
    .item       (pos_it),
    .lim_sq     (lim_sq)
  );

  sede_sobel #(.MAX_WIDTH(MAX_WIDTH)) u_sobel (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pos_v),
    .in_item   (pos_it),
    .lim_sq    (lim_sq),
    .out_valid (sob_v),
    .out_item  (sob_it),
    .out_edge  (edge_w)
  );

  sede_morph #(.MAX_WIDTH(MAX_WIDTH), .ERODE(1'b0)) u_dilate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sob_v),
    .in_item   (sob_it),
    .in_bit    (edge_w),
    .out_valid (dil_v),
    .out_item  (dil_it),
    .out_bit   (grown_w)
  );

  sede_morph #(.MAX_WIDTH(MAX_WIDTH), .ERODE(1'b1)) u_erode (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dil_v),
    .in_item   (dil_it),
    .in_bit    (grown_w),
    .out_valid (ero_v),
    .out_item  (ero_it),
    .out_bit   (white)
  );

  assign push = en && ero_v && ero_it.p3_valid;
  assign pop  = m_tvalid && m_tready;
  assign slot = fifo_cnt - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_cnt <= '0;
    end else begin
      fifo_cnt <= fifo_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && slot == 2'd0) begin
      fd0 <= {ero_it.p3_last, white};
    end else if (pop) begin
      fd0 <= fd1;
    end
    if (push && slot != 2'd0) begin
      fd1 <= {ero_it.p3_last, white};
    end
  end

  assign m_tvalid = fifo_cnt != 2'd0;
  assign m_tdata  = {6'b000000, fd0[0], 1'b1};
  assign m_tlast  = fd0[1];

  `SEDE_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_cnt != 2'd3, "output buffer overrun")
  `SEDE_ASSERT_NOW(a_stall_only_full, !s_tready, m_tvalid, "stall with no result held")
  `SEDE_ASSERT_NEXT(a_pop_drains, pop && !push, fifo_cnt == $past(fifo_cnt) - 2'd1,
                    "result count did not drop after take")

endmodule
